>>> src/mes_pkg.sv
// ============================================================================
// mes_pkg: shared types and constants for the multilinear stress block
// Holds the channel beat structs, opcode codes, register indexes and limits.
// ============================================================================
package mes_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);

    localparam logic [1:0] OP_EVAL    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [0:0] REG_DAMPING = 1'd0;
    localparam logic [0:0] REG_POINTS  = 1'd1;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         point_index;
        logic signed [31:0] strain_value;
        logic signed [31:0] strain_rate;
        logic signed [31:0] stress_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] stress_out;
        logic signed [47:0] tangent_out;
        logic [5:0]         segment_out;
    } t_out_beat;

endpackage

>>> src/mes_divider.sv
// ============================================================================
// mes_divider: bit-serial signed divider for the segment slope
// Restoring division, one quotient bit per cycle, truncation toward zero,
// result saturated to 48 bits. A zero divisor saturates by the dividend sign.
// ============================================================================
module mes_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_num,   // stress difference
    input  logic signed [32:0] i_den,   // strain difference
    output logic               o_done,
    output logic signed [47:0] o_quot
);
    // dividend magnitude is |ds| * 2^24, below 2^58
    logic [57:0] r_dvd, n_dvd;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic [57:0] r_q, n_q;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg, n_neg;
    logic        r_zero, n_zero;
    logic        r_done, n_done;
    logic [33:0] w_trial;
    logic [33:0] w_num_mag;

    assign w_num_mag = i_num[33] ? 34'(-i_num) : 34'(i_num);
    assign w_trial   = {r_rem, r_dvd[57]} - {1'b0, r_den};

    // shift one dividend bit into the remainder per cycle
    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = {w_num_mag[33:0], 24'd0};
            n_rem  = '0;
            n_den  = i_den[32] ? 33'(-i_den) : 33'(i_den);
            n_q    = '0;
            n_cnt  = '0;
            n_busy = (i_den != '0);
            n_done = (i_den == '0);
            n_neg  = i_num[33] ^ i_den[32];
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            n_dvd = {r_dvd[56:0], 1'b0};
            if (!w_trial[33]) begin
                n_rem = w_trial[32:0];
                n_q   = {r_q[56:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_dvd[57]};
                n_q   = {r_q[56:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd57) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    // apply sign and saturate; r_neg carries the dividend sign for zero divisor
    always_comb begin
        if (r_zero) begin
            o_quot = (r_dvd == '0) ? 48'sd0 : (r_neg ? mes_pkg::MIN48 : mes_pkg::MAX48);
        end else if (r_neg) begin
            o_quot = (r_q > 58'h8000_0000_0000) ? mes_pkg::MIN48 : 48'(-r_q);
        end else begin
            o_quot = (r_q > 58'h7FFF_FFFF_FFFF) ? mes_pkg::MAX48 : 48'(r_q);
        end
    end

    assign o_done = r_done;

endmodule

>>> src/multilinear_elastic_stress.sv
// ============================================================================
// multilinear_elastic_stress: piecewise linear stress-strain evaluation
// Breakpoint table, tracked segment walk, serial slope divide and a
// shift-add multiply for the stress sum.
// ============================================================================
//  channel | direction | handshake        | beat
//  in      | input     | i_valid/o_stall  | mes_pkg::t_in_beat
//  out     | output    | o_valid/i_stall  | mes_pkg::t_out_beat
//  cfg     | input     | i_cfg_we         | index + 32-bit data
//
// One item at a time. A write passes through the read and output states. An
// evaluate or restart reads the tracked segment's two points, walks the
// segment toward the strain, then runs the slope divider (no iteration for
// a segment of equal strains); an evaluate then runs the serial multiplier.
// Reset is synchronous and clears the segment, registers and control only.
// A held result blocks intake until the output beat is taken.
module multilinear_elastic_stress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mes_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output mes_pkg::t_out_beat  o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_WAIT  = 4'd2;
    localparam logic [3:0] ST_DECID = 4'd3;
    localparam logic [3:0] ST_STEP  = 4'd4;
    localparam logic [3:0] ST_RDS   = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_MUL1  = 4'd7;
    localparam logic [3:0] ST_MUL2  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_WAITS = 4'd10;
    localparam logic [3:0] ST_WALK  = 4'd11;

    localparam int IW = mes_pkg::IDX_W;

    logic signed [31:0] mem_e [mes_pkg::MAX_POINTS];
    logic signed [31:0] mem_s [mes_pkg::MAX_POINTS];

    logic [3:0]          r_st;
    logic [IW-1:0]       r_seg;
    logic signed [31:0]  r_eta;
    logic [6:0]          r_pc;
    mes_pkg::t_in_beat   r_in;
    mes_pkg::t_out_beat  r_out;
    logic [IW-1:0]       r_ra;
    logic signed [31:0]  r_e, r_s;      // registered read data
    logic signed [31:0]  r_e1, r_e2, r_s1, r_s2;
    logic                r_dir_up, r_dir_dn, r_phase;
    logic [IW-1:0]       r_top;
    logic signed [32:0]  w_strain;
    // serial multiplier
    logic [81:0]         r_acc;
    logic [47:0]         r_mcand;
    logic [47:0]         r_mplier;
    logic [5:0]          r_mcnt;
    logic                r_div_go;
    logic                w_div_done;
    logic signed [47:0]  w_quot;
    logic signed [47:0]  r_slope;
    logic [6:0]          w_pc;

    // clamp point count to the legal range
    always_comb begin
        if (r_pc < 7'd2) w_pc = 7'd2;
        else if (r_pc > 7'(mes_pkg::MAX_POINTS)) w_pc = 7'(mes_pkg::MAX_POINTS);
        else w_pc = r_pc;
    end

    assign w_strain = (r_in.opcode == mes_pkg::OP_EVAL) ? 33'(r_in.strain_value) : 33'sd0;

    mes_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (34'(r_s2) - 34'(r_s1)),
        .i_den   (33'(r_e2) - 33'(r_e1)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall = (r_st != ST_IDLE);
    assign o_data  = r_out;
    assign o_valid = (r_st == ST_OUT);

    // table write and registered reads
    always_ff @(posedge i_clk) begin
        if (r_st == ST_RD && r_in.opcode == mes_pkg::OP_WRITE) begin
            mem_e[r_in.point_index[IW-1:0]] <= r_in.strain_value;
            mem_s[r_in.point_index[IW-1:0]] <= r_in.stress_value;
        end
        r_e <= mem_e[r_ra];
        r_s <= mem_s[r_ra];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta <= '0;
            r_pc  <= 7'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mes_pkg::REG_DAMPING) r_eta <= i_cfg_data;
            else r_pc <= i_cfg_data[6:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_seg    <= '0;
            r_div_go <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                        r_st <= ST_RD;
                        if (i_data.opcode == mes_pkg::OP_RESTART) r_seg <= '0;
                    end
                end
                ST_RD: begin
                    r_top <= IW'(w_pc - 7'd2);
                    if (r_in.opcode == mes_pkg::OP_EVAL || r_in.opcode == mes_pkg::OP_RESTART) begin
                        if (r_seg > IW'(w_pc - 7'd2)) r_seg <= IW'(w_pc - 7'd2);
                        r_ra    <= (r_seg > IW'(w_pc - 7'd2)) ? IW'(w_pc - 7'd2) : r_seg;
                        r_phase <= 1'b0;
                        r_st    <= ST_WAIT;
                    end else begin
                        r_out <= '{stress_out: '0, tangent_out: '0, segment_out: 6'(r_seg)};
                        r_st  <= ST_OUT;
                    end
                end
                ST_WAIT: begin
                    // first read lands next cycle; then read upper point
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_ra    <= r_ra + IW'(1);
                    end else begin
                        r_e1  <= r_e;
                        r_s1  <= r_s;
                        r_st  <= ST_WAITS;
                    end
                end
                ST_WAITS: begin
                    r_e2 <= r_e;
                    r_s2 <= r_s;
                    r_st <= ST_DECID;
                end
                ST_DECID: begin
                    r_dir_up <= (w_strain >= 33'(r_e2)) && (r_seg < r_top);
                    r_dir_dn <= !((w_strain >= 33'(r_e2)) && (r_seg < r_top)) &&
                                (w_strain < 33'(r_e1)) && (r_seg != '0);
                    r_st     <= ST_STEP;
                end
                ST_STEP: begin
                    if (r_dir_up && w_strain >= 33'(r_e2) && r_seg < r_top) begin
                        r_seg <= r_seg + IW'(1);
                        r_e1  <= r_e2;
                        r_s1  <= r_s2;
                        r_ra  <= r_seg + IW'(2);
                        r_st  <= ST_WALK;
                    end else if (r_dir_dn && w_strain <= 33'(r_e1) && r_seg != '0) begin
                        r_seg <= r_seg - IW'(1);
                        r_e2  <= r_e1;
                        r_s2  <= r_s1;
                        r_ra  <= r_seg - IW'(1);
                        r_st  <= ST_WALK;
                    end else begin
                        r_div_go <= 1'b1;
                        r_st     <= ST_DIV;
                    end
                end
                ST_WALK: r_st <= ST_RDS;
                ST_RDS: begin
                    if (r_dir_up) begin
                        r_e2 <= r_e;
                        r_s2 <= r_s;
                    end else begin
                        r_e1 <= r_e;
                        r_s1 <= r_s;
                    end
                    r_st <= ST_STEP;
                end
                ST_DIV: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_slope <= w_quot;
                        if (r_in.opcode == mes_pkg::OP_EVAL) begin
                            // acc = s1*2^24 + slope*(strain-e1) + eta*rate
                            r_acc    <= 82'(signed'(r_s1)) <<< 24;
                            r_mcand  <= w_quot;
                            r_mplier <= 48'(w_strain - 33'(r_e1));
                            r_mcnt   <= '0;
                            r_st     <= ST_MUL1;
                        end else begin
                            r_out <= '{stress_out: '0, tangent_out: w_quot,
                                       segment_out: 6'(r_seg)};
                            r_st  <= ST_OUT;
                        end
                    end
                end
                ST_MUL1: begin
                    // one multiplier bit per cycle, top bit weighted negative
                    if (r_mcnt == 6'd47) begin
                        if (r_mplier[0])
                            r_acc <= r_acc - (82'(signed'(r_mcand)) << r_mcnt);
                        r_mcand  <= 48'(r_eta);
                        r_mplier <= 48'(r_in.strain_rate);
                        r_mcnt   <= '0;
                        r_st     <= ST_MUL2;
                    end else begin
                        if (r_mplier[0])
                            r_acc <= r_acc + (82'(signed'(r_mcand)) << r_mcnt);
                        r_mplier <= {r_mplier[47], r_mplier[47:1]};
                        r_mcnt   <= r_mcnt + 6'd1;
                    end
                end
                ST_MUL2: begin
                    if (r_mcnt == 6'd32) begin
                        r_st <= ST_OUT;
                        r_out.tangent_out <= r_slope;
                        r_out.segment_out <= 6'(r_seg);
                        if (!r_acc[81] && r_acc[80:55] != '0)
                            r_out.stress_out <= 32'sh7FFF_FFFF;
                        else if (r_acc[81] && r_acc[80:55] != '1)
                            r_out.stress_out <= 32'sh8000_0000;
                        else
                            r_out.stress_out <= r_acc[55:24];
                        r_mcnt <= '0;
                    end else begin
                        if (r_mplier[0]) begin
                            if (r_mcnt == 6'd31)
                                r_acc <= r_acc - (82'(signed'(r_mcand)) << r_mcnt);
                            else
                                r_acc <= r_acc + (82'(signed'(r_mcand)) << r_mcnt);
                        end
                        r_mplier <= {r_mplier[47], r_mplier[47:1]};
                        r_mcnt   <= r_mcnt + 6'd1;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result beat never exists while the block is taking input
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall)
        else $error("output valid while input open");
    // a stalled result holds its beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");
    // tracked segment stays within the table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_STEP) |-> (r_seg <= r_top))
        else $error("segment beyond top");
`endif

endmodule
